// ===== rtl/ctp_pkg.sv =====
`default_nettype none
package ctp_pkg;

  localparam int FRAC   = 16;
  localparam int W      = 32;
  localparam int REG_W  = 31;
  localparam int NUM_W  = W + FRAC;
  localparam int ES_W   = NUM_W + 1;
  localparam int DIFF_W = ES_W + 1;
  localparam int KE_W   = 2 * W - FRAC - 1;
  localparam int PROD_W = 2 * REG_W + W;
  localparam int SH_W   = PROD_W - 2 * FRAC;

  localparam logic [REG_W-1:0] CAP_RESET = REG_W'(64'd1 << FRAC);

  localparam logic REG_CV = 1'b0;
  localparam logic REG_CP = 1'b1;

  typedef logic signed [W-1:0] word_t;

  localparam word_t WMAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    word_t density;
    word_t momentum_x;
    word_t momentum_y;
    word_t energy;
    word_t density_step;
    word_t momentum_x_step;
    word_t momentum_y_step;
    word_t energy_step;
  } in_t;

  typedef struct packed {
    word_t new_density;
    word_t new_momentum_x;
    word_t new_momentum_y;
    word_t new_energy;
    word_t velocity_x;
    word_t velocity_y;
    word_t temperature;
    word_t pressure;
    logic  status;
  } out_t;

  typedef struct packed {
    word_t rho;
    word_t mx;
    word_t my;
    word_t en;
    logic  bad;
  } cons_t;

  typedef struct packed {
    cons_t c;
    word_t vx;
    word_t vy;
  } mid_t;

  typedef struct packed {
    logic [REG_W-1:0] rem;
    logic [NUM_W-1:0] bits;
    logic [REG_W-1:0] den;
    logic             neg;
  } div_st_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      sat_add = s[W] ? WMIN : WMAX;
    end else begin
      sat_add = s[W-1:0];
    end
  endfunction

  function automatic word_t sat_wide(logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = {{(DIFF_W-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      sat_wide = WMAX;
    end else if (v < lo) begin
      sat_wide = WMIN;
    end else begin
      sat_wide = v[W-1:0];
    end
  endfunction

  function automatic logic [W-1:0] mag(word_t a);
    mag = a[W-1] ? -a : a;
  endfunction

  function automatic logic signed [DIFF_W-1:0] signed_quo(logic [NUM_W-1:0] q, logic neg);
    logic [DIFF_W-1:0] e;
    e = {{(DIFF_W-NUM_W){1'b0}}, q};
    signed_quo = neg ? -e : e;
  endfunction

  // one restoring division step: next dividend bit in, one quotient bit out
  function automatic div_st_t div_step(div_st_t s);
    logic [REG_W:0] r;
    div_st_t n;
    r = {s.rem, s.bits[NUM_W-1]};
    n = s;
    n.bits = {s.bits[NUM_W-2:0], 1'b0};
    if (r >= {1'b0, s.den}) begin
      r = r - {1'b0, s.den};
      n.bits[0] = 1'b1;
    end
    n.rem = r[REG_W-1:0];
    div_step = n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ctp_if.sv =====
`default_nettype none
interface ctp_in_if;
  logic           valid;
  logic           ready;
  ctp_pkg::in_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctp_out_if;
  logic           valid;
  logic           ready;
  ctp_pkg::out_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ctp_div.sv =====
`default_nettype none
module ctp_div (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [ctp_pkg::NUM_W-1:0]   num_i,
  input  wire logic [ctp_pkg::REG_W-1:0]   den_i,
  input  wire logic                        neg_i,
  output logic      [ctp_pkg::NUM_W-1:0]   quo_o,
  output logic                             neg_o
);

  ctp_pkg::div_st_t st_in;
  ctp_pkg::div_st_t st_q [ctp_pkg::NUM_W];

  assign st_in = '{rem: '0, bits: num_i, den: den_i, neg: neg_i};

  for (genvar k = 0; k < ctp_pkg::NUM_W; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) st_q[0] <= ctp_pkg::div_step(st_in);
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) st_q[k] <= ctp_pkg::div_step(st_q[k-1]);
      end
    end
  end

  assign quo_o = st_q[ctp_pkg::NUM_W-1].bits;
  assign neg_o = st_q[ctp_pkg::NUM_W-1].neg;

endmodule
`default_nettype wire

// ===== rtl/ctp_pres.sv =====
`default_nettype none
module ctp_pres (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire ctp_pkg::word_t             g_i,
  input  wire logic [ctp_pkg::REG_W-1:0]  rho_i,
  input  wire ctp_pkg::word_t             t_i,
  output ctp_pkg::word_t                  p_o
);

  localparam int W = ctp_pkg::W;
  localparam int MW = 2 * ctp_pkg::REG_W;

  logic [W-1:0]  gm;
  logic [MW-1:0] m_q;
  logic [W-1:0]  tm_q;
  logic          neg1_q;
  logic [2*W-1:0] p0_q;
  logic [MW-1:0]  p1_q;
  logic           neg2_q;

  logic [ctp_pkg::PROD_W-1:0] sum;
  logic [ctp_pkg::SH_W-1:0]   r;
  logic [ctp_pkg::SH_W-1:0]   rn;
  logic [ctp_pkg::SH_W-1:0]   lim;

  assign gm = ctp_pkg::mag(g_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= gm[ctp_pkg::REG_W-1:0] * rho_i;
      tm_q   <= ctp_pkg::mag(t_i);
      neg1_q <= g_i[W-1] ^ t_i[W-1];
      p0_q   <= m_q[W-1:0] * tm_q;
      p1_q   <= m_q[MW-1:W] * tm_q;
      neg2_q <= neg1_q;
    end
  end

  always_comb begin
    sum = ctp_pkg::PROD_W'(p0_q) + (ctp_pkg::PROD_W'(p1_q) << W);
    r   = sum[ctp_pkg::PROD_W-1:2*ctp_pkg::FRAC];
    rn  = -r;
    lim = {{(ctp_pkg::SH_W-W){1'b0}}, neg2_q, {(W-1){~neg2_q}}};
    if (r > lim) begin
      p_o = neg2_q ? ctp_pkg::WMIN : ctp_pkg::WMAX;
    end else begin
      p_o = neg2_q ? rn[W-1:0] : r[W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/conserved_to_primitive_update.sv =====
`default_nettype none
// Per-node conserved-to-primitive update for an ideal gas, Q16.16 signed.
// One node beat is accepted per cycle unless the pipeline holds. The dividers give one
// quotient bit per stage: three in parallel for the divisions by density, one for the
// division by cv. The whole pipeline holds while a finished result is not taken. The
// user must write cv and cp through the cfg port only while no beats are in flight;
// the block does not enforce this. Both reset to 1.0.
module conserved_to_primitive_update (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [ctp_pkg::REG_W-1:0]  cfg_wdata_i,
  ctp_in_if.sink                          in_i,
  ctp_out_if.source                       out_o
);

  localparam int W  = ctp_pkg::W;
  localparam int NW = ctp_pkg::NUM_W;
  localparam int RW = ctp_pkg::REG_W;

  logic [RW-1:0] cv_q, cp_q;
  logic          en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= ctp_pkg::CAP_RESET;
      cp_q <= ctp_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ctp_pkg::REG_CV: cv_q <= cfg_wdata_i;
        ctp_pkg::REG_CP: cp_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic out_v_q;
  assign en = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // add increments
  ctp_pkg::cons_t c0_d, c0_q;
  logic           v0_q;

  always_comb begin
    c0_d.rho = ctp_pkg::sat_add(in_i.data.density, in_i.data.density_step);
    c0_d.mx  = ctp_pkg::sat_add(in_i.data.momentum_x, in_i.data.momentum_x_step);
    c0_d.my  = ctp_pkg::sat_add(in_i.data.momentum_y, in_i.data.momentum_y_step);
    c0_d.en  = ctp_pkg::sat_add(in_i.data.energy, in_i.data.energy_step);
    c0_d.bad = (c0_d.rho <= 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) c0_q <= c0_d;
  end

  // divide by density
  logic [NW-1:0] qx, qy, qe;
  logic          nx, ny, ne;

  ctp_div u_div_x (
    .clk_i, .en_i(en),
    .num_i({ctp_pkg::mag(c0_q.mx), {ctp_pkg::FRAC{1'b0}}}),
    .den_i(c0_q.rho[RW-1:0]), .neg_i(c0_q.mx[W-1]),
    .quo_o(qx), .neg_o(nx)
  );
  ctp_div u_div_y (
    .clk_i, .en_i(en),
    .num_i({ctp_pkg::mag(c0_q.my), {ctp_pkg::FRAC{1'b0}}}),
    .den_i(c0_q.rho[RW-1:0]), .neg_i(c0_q.my[W-1]),
    .quo_o(qy), .neg_o(ny)
  );
  ctp_div u_div_e (
    .clk_i, .en_i(en),
    .num_i({ctp_pkg::mag(c0_q.en), {ctp_pkg::FRAC{1'b0}}}),
    .den_i(c0_q.rho[RW-1:0]), .neg_i(c0_q.en[W-1]),
    .quo_o(qe), .neg_o(ne)
  );

  ctp_pkg::cons_t da_q [NW];
  ctp_pkg::mid_t  db_q [NW];
  logic [NW-1:0]  va_q, vb_q;

  // quotients to velocity and specific energy, then specific energy less kinetic energy
  logic signed [ctp_pkg::DIFF_W-1:0] es_w;
  ctp_pkg::cons_t c1_q, c2_q, c3_q;
  ctp_pkg::word_t vx1_q, vy1_q, vx2_q, vy2_q, vx3_q, vy3_q, q3_q;
  logic signed [ctp_pkg::ES_W-1:0] es1_q, es2_q;
  logic signed [2*W-1:0] sqx_q, sqy_q;
  logic v1_q, v2_q, v3_q;

  logic [2*W-1:0]               kesum;
  logic [ctp_pkg::KE_W-1:0]     ke;
  logic signed [ctp_pkg::DIFF_W-1:0] diff;

  assign es_w = ctp_pkg::signed_quo(qe, ne);

  always_comb begin
    kesum = sqx_q + sqy_q;
    ke    = kesum[2*W-1:ctp_pkg::FRAC+1];
    diff  = $signed({es2_q[ctp_pkg::ES_W-1], es2_q}) -
            $signed({{(ctp_pkg::DIFF_W-ctp_pkg::KE_W){1'b0}}, ke});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      da_q[0] <= c0_q;
      for (int k = 1; k < NW; k++) da_q[k] <= da_q[k-1];
      c1_q  <= da_q[NW-1];
      vx1_q <= ctp_pkg::sat_wide(ctp_pkg::signed_quo(qx, nx));
      vy1_q <= ctp_pkg::sat_wide(ctp_pkg::signed_quo(qy, ny));
      es1_q <= es_w[ctp_pkg::ES_W-1:0];
      c2_q  <= c1_q;
      vx2_q <= vx1_q;
      vy2_q <= vy1_q;
      es2_q <= es1_q;
      sqx_q <= vx1_q * vx1_q;
      sqy_q <= vy1_q * vy1_q;
      c3_q  <= c2_q;
      vx3_q <= vx2_q;
      vy3_q <= vy2_q;
      q3_q  <= ctp_pkg::sat_wide(diff);
    end
  end

  // divide by cv
  logic [RW-1:0] cv_eff;
  logic [NW-1:0] qt;
  logic          nt;

  assign cv_eff = (cv_q == '0) ? RW'(1) : cv_q;

  ctp_div u_div_t (
    .clk_i, .en_i(en),
    .num_i({ctp_pkg::mag(q3_q), {ctp_pkg::FRAC{1'b0}}}),
    .den_i(cv_eff), .neg_i(q3_q[W-1]),
    .quo_o(qt), .neg_o(nt)
  );

  // pressure, then output register with primitives cleared on bad density
  ctp_pkg::mid_t  m4_q, m5_q, m6_q;
  ctp_pkg::word_t t4_q, t5_q, t6_q, pres;
  ctp_pkg::word_t g;
  logic           v4_q, v5_q, v6_q;

  assign g = W'({1'b0, cp_q}) - W'({1'b0, cv_q});

  ctp_pres u_pres (
    .clk_i, .en_i(en), .g_i(g), .rho_i(m4_q.c.rho[RW-1:0]), .t_i(t4_q), .p_o(pres)
  );

  ctp_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      db_q[0] <= '{c: c3_q, vx: vx3_q, vy: vy3_q};
      for (int k = 1; k < NW; k++) db_q[k] <= db_q[k-1];
      m4_q <= db_q[NW-1];
      t4_q <= ctp_pkg::sat_wide(ctp_pkg::signed_quo(qt, nt));
      m5_q <= m4_q;
      t5_q <= t4_q;
      m6_q <= m5_q;
      t6_q <= t5_q;
      out_q.new_density    <= m6_q.c.rho;
      out_q.new_momentum_x <= m6_q.c.mx;
      out_q.new_momentum_y <= m6_q.c.my;
      out_q.new_energy     <= m6_q.c.en;
      out_q.velocity_x     <= m6_q.c.bad ? '0 : m6_q.vx;
      out_q.velocity_y     <= m6_q.c.bad ? '0 : m6_q.vy;
      out_q.temperature    <= m6_q.c.bad ? '0 : t6_q;
      out_q.pressure       <= m6_q.c.bad ? '0 : pres;
      out_q.status         <= m6_q.c.bad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      va_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vb_q    <= '0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v0_q    <= in_i.valid;
      va_q    <= {va_q[NW-2:0], v0_q};
      v1_q    <= va_q[NW-1];
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vb_q    <= {vb_q[NW-2:0], v3_q};
      v4_q    <= vb_q[NW-1];
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      out_v_q <= v6_q;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.status |->
      out_q.velocity_x == 0 && out_q.velocity_y == 0 &&
      out_q.temperature == 0 && out_q.pressure == 0)
    else $error("primitives not cleared on bad density");

  a_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.status == ($signed(out_q.new_density) <= 0))
    else $error("status does not match density");

  a_enter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v0_q)
    else $error("accepted beat lost at entry");

  a_no_gas : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.status && cp_q == cv_q |-> out_q.pressure == 0)
    else $error("pressure nonzero with cp equal to cv");

endmodule
`default_nettype wire

// ===== dv/conserved_to_primitive_update_checker.sv =====
`timescale 1ns / 1ps
module conserved_to_primitive_update_checker
  import ctp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [REG_W-1:0]  cfg_wdata_i,
  ctp_in_if                      in_i,
  ctp_out_if                     out_o,
  output int                     fails_o,
  output int                     pending_o,
  output int                     nodes_o,
  output int                     bad_density_o
);

  logic [REG_W-1:0] cv_q;
  logic [REG_W-1:0] cp_q;
  out_t             node_results_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic out_t node_update(in_t n, logic [REG_W-1:0] cv_r,
                                       logic [REG_W-1:0] cp_r);
    longint       rho, mx, my, en, vx, vy, es, q, t, cvd, g, p, lim;
    logic [63:0]  ke;
    logic [127:0] pm;
    logic [127:0] pr;
    logic         neg;
    out_t         o;
    rho = clip32(longint'(n.density) + longint'(n.density_step));
    mx  = clip32(longint'(n.momentum_x) + longint'(n.momentum_x_step));
    my  = clip32(longint'(n.momentum_y) + longint'(n.momentum_y_step));
    en  = clip32(longint'(n.energy) + longint'(n.energy_step));
    vx = 0; vy = 0; t = 0; p = 0;
    o.status = (rho <= 0);
    if (rho > 0) begin
      cvd = (cv_r == '0) ? 1 : longint'({1'b0, cv_r});
      vx = clip32((mx * (64'sd1 << FRAC)) / rho);
      vy = clip32((my * (64'sd1 << FRAC)) / rho);
      ke = (64'(vx * vx) + 64'(vy * vy)) >> (FRAC + 1);
      es = (en * (64'sd1 << FRAC)) / rho;
      q  = clip32(es - longint'(ke));
      t  = clip32((q * (64'sd1 << FRAC)) / cvd);
      // gas constant: cp - cv, may be negative
      g   = longint'({1'b0, cp_r}) - longint'({1'b0, cv_r});
      neg = (g < 0) != (t < 0);
      pm  = 128'(g < 0 ? -g : g) * 128'(rho) * 128'(t < 0 ? -t : t);
      pr  = pm >> (2 * FRAC);
      lim = neg ? 64'sd2147483648 : 64'sd2147483647;
      if (g == 0 || t == 0) begin
        p = 0;
      end else if (pr > 128'(lim)) begin
        p = neg ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
        p = neg ? -longint'(pr[63:0]) : longint'(pr[63:0]);
      end
    end
    o.new_density    = word_t'(rho);
    o.new_momentum_x = word_t'(mx);
    o.new_momentum_y = word_t'(my);
    o.new_energy     = word_t'(en);
    o.velocity_x     = word_t'(vx);
    o.velocity_y     = word_t'(vy);
    o.temperature    = word_t'(t);
    o.pressure       = word_t'(p);
    return o;
  endfunction

  assign pending_o = node_results_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t        exp_r;
    out_t        got_r;
    logic [31:0] ev[9];
    logic [31:0] gv[9];
    string       nm[9];
    bit          bad;
    if (!rst_ni) begin
      cv_q <= CAP_RESET;
      cp_q <= CAP_RESET;
      fails_o = 0;
      nodes_o = 0;
      bad_density_o = 0;
      node_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CV) cv_q <= cfg_wdata_i;
        else cp_q <= cfg_wdata_i;
      end
      if (out_o.valid && out_o.ready) begin
        got_r = out_o.data;
        if (node_results_q.size() == 0) begin
          fails_o++;
          if (fails_o <= 10) $display("%0t: unexpected result beat %p", $realtime, got_r);
        end else begin
          exp_r = node_results_q.pop_front();
          nm = '{"new_density", "new_momentum_x", "new_momentum_y", "new_energy",
                 "velocity_x", "velocity_y", "temperature", "pressure", "status"};
          ev = '{exp_r.new_density, exp_r.new_momentum_x, exp_r.new_momentum_y,
                 exp_r.new_energy, exp_r.velocity_x, exp_r.velocity_y,
                 exp_r.temperature, exp_r.pressure, 32'(exp_r.status)};
          gv = '{got_r.new_density, got_r.new_momentum_x, got_r.new_momentum_y,
                 got_r.new_energy, got_r.velocity_x, got_r.velocity_y,
                 got_r.temperature, got_r.pressure, 32'(got_r.status)};
          bad = 0;
          foreach (ev[k]) begin
            if (ev[k] !== gv[k]) begin
              if (!bad) fails_o++;
              bad = 1;
              if (fails_o <= 10)
                $display("%0t: %s expected %h got %h", $realtime, nm[k], ev[k], gv[k]);
            end
          end
          if (exp_r.status) bad_density_o++;
        end
      end
      if (in_i.valid && in_i.ready) begin
        node_results_q.push_back(node_update(in_i.data, cv_q, cp_q));
        nodes_o++;
      end
    end
  end

endmodule

// ===== dv/conserved_to_primitive_update_test.sv =====
`timescale 1ns / 1ps
module conserved_to_primitive_update_test;
  import ctp_pkg::*;

  localparam int LIMIT = 600000;
  localparam int PER_PHASE = 140;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_CV;
  logic [REG_W-1:0] cfg_wdata_i = '0;
  int               fails, pending, nodes, bad_density;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               cycles = 0;

  ctp_in_if  node_in ();
  ctp_out_if node_out ();

  initial begin
    node_in.valid = 1'b0;
    node_in.data = '0;
    node_out.ready = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  conserved_to_primitive_update dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_i(node_in), .out_o(node_out)
  );

  conserved_to_primitive_update_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_i(node_in), .out_o(node_out),
    .fails_o(fails), .pending_o(pending), .nodes_o(nodes), .bad_density_o(bad_density)
  );

  always @(posedge clk_i) begin
    node_out.ready <= ($urandom_range(99) >= stall_pct);
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** conserved_to_primitive_update: FAILED **");
      $finish;
    end
  end

  task automatic send_node(in_t n);
    while ($urandom_range(99) < send_idle_pct) begin
      node_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    node_in.valid <= 1'b1;
    node_in.data <= n;
    do @(posedge clk_i); while (!node_in.ready);
  endtask

  task automatic write_cap(logic idx, logic [REG_W-1:0] val);
    node_in.valid <= 1'b0;
    wait (pending == 0);
    repeat (120) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic word_t pick_word();
    word_t ext[5] = '{WMIN, WMAX, 32'sd0, 32'sd1, -32'sd1};
    case ($urandom_range(9))
      0:       return ext[$urandom_range(4)];
      1, 2:    return word_t'($urandom);
      default: return word_t'($urandom_range(1 << 22)) - (32'sd1 << 21);
    endcase
  endfunction

  function automatic in_t random_node();
    in_t n;
    if ($urandom_range(99) < 20) begin
      n = {pick_word(), pick_word(), pick_word(), pick_word(),
           pick_word(), pick_word(), pick_word(), pick_word()};
    end else begin
      n.density = word_t'($urandom_range(1 << 22, 1 << 10));
      n.density_step = word_t'($urandom_range(1 << 12)) - (32'sd1 << 11);
      n.momentum_x = pick_word();
      n.momentum_y = pick_word();
      n.energy = word_t'($urandom_range(1 << 26));
      n.momentum_x_step = pick_word();
      n.momentum_y_step = pick_word();
      n.energy_step = pick_word();
    end
    return n;
  endfunction

  function automatic in_t mk(word_t d, word_t mx, word_t my, word_t e,
                             word_t ds, word_t mxs, word_t mys, word_t es);
    return '{d, mx, my, e, ds, mxs, mys, es};
  endfunction

  initial begin
    logic [REG_W-1:0] cv_set[6];
    logic [REG_W-1:0] cp_set[6];
    int               idle_tab[4];
    int               stall_tab[4];
    cv_set = '{CAP_RESET, {REG_W{1'b1}}, 31'd1, 31'd0, 31'h30000, 31'(65536 + 45875)};
    cp_set = '{CAP_RESET, 31'd0, {REG_W{1'b1}}, 31'h30000, 31'h10000, 31'(92000)};
    idle_tab = '{0, 73, 0, 26};
    stall_tab = '{0, 0, 73, 26};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturating adds, non-positive density, tiny density, big energy
    send_node(mk(WMAX, WMAX, WMIN, WMAX, WMAX, WMAX, WMIN, WMAX));
    send_node(mk(WMIN, WMIN, WMAX, WMIN, WMIN, WMIN, WMAX, WMIN));
    send_node(mk(0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0));
    send_node(mk(-32'sd5, 32'sh10000, 0, 32'sh10000, 0, 0, 0, 0));
    send_node(mk(WMIN, 0, 0, 0, 0, 0, 0, 0));
    send_node(mk(1, WMAX, WMIN, WMAX, 0, 0, 0, 0));
    send_node(mk(1, 0, 0, WMIN, 0, 0, 0, 0));
    send_node(mk(32'sh10000, 32'sh20000, -32'sh30000, 32'sh80000, 0, 0, 0, 0));
    send_node(mk(32'sh8000, 32'sh10000, 32'sh10000, 32'sh40000, 32'sh8000, 0, 0, 0));
    send_node(mk(WMAX, WMAX, WMAX, WMAX, 0, 0, 0, 0));
    send_node(mk(WMAX, 0, 0, 0, 0, 0, 0, 0));
    send_node(mk(32'sh10000, 32'sh100000, 32'sh100000, 0, 0, 0, 0, 0));
    send_node(mk(32'sh10000, 0, 0, 32'sh7FFF0000, 0, 0, 0, 32'sh10000));
    send_node(mk(1, 1, -1, -1, 0, -1, 1, 1));
    send_node(mk(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555));

    for (int ph = 0; ph < 6; ph++) begin
      write_cap(REG_CV, cv_set[ph]);
      write_cap(REG_CP, cp_set[ph]);
      if (ph == 5) begin
        write_cap(REG_CV, 31'($urandom));
        write_cap(REG_CP, 31'($urandom));
      end
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = idle_tab[(ph + m) % 4];
        stall_pct = stall_tab[(ph + m) % 4];
        for (int i = 0; i < PER_PHASE / 4; i++) send_node(random_node());
      end
    end
    node_in.valid <= 1'b0;
    stall_pct = 0;
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("%0d nodes over six cv/cp settings, %0d with non-positive density",
             nodes, bad_density);
    if (fails == 0) begin
      $display("** conserved_to_primitive_update: PASSED **");
    end else begin
      $display("%0d mismatching beats", fails);
      $display("** conserved_to_primitive_update: FAILED **");
    end
    $finish;
  end

endmodule
